@@ rtl/core/rlf_pkg.sv @@
// ----------------------------------------------------------------------------
// rlf_pkg
// Types, constants and fixed-point helpers for the recursive lattice filter.
// ----------------------------------------------------------------------------
package rlf_pkg;

  localparam int ORDER     = 8;   // lattice order, 1..8
  localparam int NCOEF     = 8;   // coefficient registers
  localparam int SMP_W     = 16;  // sample width
  localparam int COEF_W    = 16;  // Q1.15 coefficient width
  localparam int ACC_W     = 32;  // internal value width
  localparam int PROD_W    = COEF_W + ACC_W;
  localparam int RND_W     = PROD_W - 15;
  localparam int SUM_W     = RND_W + 1;
  localparam int CFG_IDX_W = 8;
  localparam int CI_W      = $clog2(NCOEF);
  localparam int ST_W      = (ORDER > 1) ? $clog2(ORDER) : 1;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [ST_W-1:0]          stg_t;
  typedef logic [CI_W-1:0]          cidx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FMUL,
    S_FADD,
    S_BMUL,
    S_BSUB,
    S_LAST
  } state_e;

  // shift right by 15, rounding half toward plus infinity
  function automatic rnd_t round_prod(prod_t p);
    prod_t tmp;
    tmp = p + prod_t'(16384);
    return tmp[PROD_W-1:15];
  endfunction

  function automatic acc_t sat_acc(sum_t v);
    acc_t res;
    if (v > sum_t'(32'sh7fff_ffff)) begin
      res = acc_t'(32'sh7fff_ffff);
    end else if (v < sum_t'(32'sh8000_0000)) begin
      res = acc_t'(32'sh8000_0000);
    end else begin
      res = v[ACC_W-1:0];
    end
    return res;
  endfunction

  function automatic smp_t sat_smp(acc_t v);
    smp_t res;
    if (v > acc_t'(32767)) begin
      res = smp_t'(16'sh7fff);
    end else if (v < acc_t'(-32768)) begin
      res = smp_t'(16'sh8000);
    end else begin
      res = v[SMP_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/rlf_if.sv @@
// ----------------------------------------------------------------------------
// rlf interfaces
// Valid/ready channels for samples in, samples out and register writes.
// ----------------------------------------------------------------------------
interface rlf_in_if import rlf_pkg::*; ();
  logic valid;
  logic ready;
  smp_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface rlf_out_if import rlf_pkg::*; ();
  logic valid;
  logic ready;
  smp_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface rlf_cfg_if import rlf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/rlf_ram.sv @@
// ----------------------------------------------------------------------------
// rlf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rlf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/recursive_lattice_filter.sv @@
// ----------------------------------------------------------------------------
// recursive_lattice_filter
// All-pole lattice filter, fixed point, backward values held in a RAM.
// ----------------------------------------------------------------------------
// One sample word is taken at a time: a new sample word is accepted only
// in the idle state, after the result word of the last one has gone into
// the output register, which waits while the output side is stalled. All
// products go through the single shared 16x32 multiplier: each lattice
// stage runs a forward product and saturating add, then a backward product
// and saturating subtract whose result is written back to the backward-value
// RAM; the next stage's RAM read is issued during the backward product so it
// overlaps the subtract. The first stage has no backward product. Backward
// values read as zero after reset through a valid bit per entry, so no
// clearing pass is needed. Register writes are always accepted;
// coefficients are Q1.15 and only coef_0..coef_{ORDER-1} take effect.
// ----------------------------------------------------------------------------
module recursive_lattice_filter import rlf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rlf_cfg_if.sink   cfg_i,
  rlf_in_if.sink    in_i,
  rlf_out_if.source out_o
);

  localparam stg_t LAST_STG = stg_t'(ORDER - 1);

  state_e state_q, state_d;

  coef_t coef_q [NCOEF];
  stg_t  stg_q, stg_d;
  acc_t  f_q, f_d;
  acc_t  b_q, b_d;
  prod_t prod_q, prod_d;
  logic  [ORDER-1:0] vld_q;
  logic  rd_vld_q;
  logic  out_valid_q, out_valid_d;
  smp_t  out_data_q, out_data_d;

  logic  re, we;
  stg_t  raddr, waddr;
  acc_t  wdata;
  acc_t  rdata;
  acc_t  bval;
  cidx_t cidx;
  coef_t mul_a;
  acc_t  mul_b;
  prod_t mul_p;
  rnd_t  rnd;
  sum_t  fsum, bdiff;
  logic  out_load;

  // backward values b[1..ORDER] at addresses 0..ORDER-1
  rlf_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ORDER)
  ) u_bram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign bval = rd_vld_q ? rdata : '0;

  // stage i uses c[ORDER-i]; the merged subtract cycle already multiplies for the next stage
  always_comb begin
    if (state_q == S_BSUB) begin
      cidx = cidx_t'(ORDER - 1) - cidx_t'(stg_q) - cidx_t'(1);
    end else begin
      cidx = cidx_t'(ORDER - 1) - cidx_t'(stg_q);
    end
  end

  assign mul_a = coef_q[cidx];
  assign mul_b = (state_q == S_BMUL) ? f_q : bval;
  assign mul_p = mul_a * mul_b;
  assign rnd   = round_prod(prod_q);
  assign fsum  = sum_t'(f_q) + sum_t'(rnd);
  assign bdiff = sum_t'(b_q) - sum_t'(rnd);

  assign out_load = (state_q == S_LAST) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_FMUL;
        end
      end
      S_FMUL: state_d = S_FADD;
      S_FADD: begin
        if (stg_q == LAST_STG) begin
          state_d = (stg_q == '0) ? S_LAST : S_BMUL;
        end else if (stg_q == '0) begin
          state_d = S_FMUL;
        end else begin
          state_d = S_BMUL;
        end
      end
      S_BMUL: state_d = S_BSUB;
      S_BSUB: state_d = (stg_q == LAST_STG) ? S_LAST : S_FADD;
      S_LAST: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    stg_d       = stg_q;
    f_d         = f_q;
    b_d         = b_q;
    prod_d      = prod_q;
    re          = 1'b0;
    raddr       = stg_q + stg_t'(1);
    we          = 1'b0;
    waddr       = stg_q - stg_t'(1);
    wdata       = sat_acc(bdiff);
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          f_d   = acc_t'(in_i.sample_in);
          stg_d = '0;
          re    = 1'b1;
          raddr = '0;
        end
      end
      S_FMUL: begin
        prod_d = mul_p;
        b_d    = bval;
      end
      S_FADD: begin
        f_d = sat_acc(fsum);
        if (stg_q == '0 && stg_q != LAST_STG) begin
          re    = 1'b1;
          stg_d = stg_q + stg_t'(1);
        end
      end
      S_BMUL: begin
        prod_d = mul_p;
        if (stg_q != LAST_STG) begin
          re = 1'b1;
        end
      end
      S_BSUB: begin
        we = 1'b1;
        if (stg_q != LAST_STG) begin
          stg_d  = stg_q + stg_t'(1);
          prod_d = mul_p;
          b_d    = bval;
        end
      end
      S_LAST: begin
        we    = 1'b1;
        waddr = LAST_STG;
        wdata = f_q;
        if (out_load) begin
          out_valid_d = 1'b1;
          out_data_d  = sat_smp(f_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stg_q       <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NCOEF; k++) begin
        coef_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      stg_q       <= stg_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_q <= vld_q[raddr];
      end
      if (cfg_i.valid && cfg_i.index < CFG_IDX_W'(NCOEF)) begin
        coef_q[cfg_i.index[CI_W-1:0]] <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_q        <= f_d;
    b_q        <= b_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

endmodule

@@ tb/lattice_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_checker
// Watches the register, sample and result channels of the lattice filter,
// recomputes each filtered sample in fixed point and compares it with the
// word the block hands out.
// ----------------------------------------------------------------------------
module lattice_checker import rlf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rlf_cfg_if   cfg_mon,
  rlf_in_if    in_mon,
  rlf_out_if   out_mon,
  output int   mismatch_cnt_o,
  output int   pending_o
);

  coef_t coef_q [NCOEF];
  acc_t  bkwd_q [1:ORDER];
  smp_t  filtered_q [$];
  int    mismatches = 0;
  int    seen_out   = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // q1.15 times a 32-bit value, rounded half up, shifted right by 15
  function automatic longint q15_mul(coef_t c, longint v);
    longint p;
    p = longint'(c) * v;
    return (p + 64'sd16384) >>> 15;
  endfunction

  function automatic smp_t filter_sample(smp_t x);
    longint fw [0:ORDER];
    longint y;
    fw[0] = longint'(x);
    for (int i = 1; i <= ORDER; i++) begin
      fw[i] = clamp32(q15_mul(coef_q[ORDER-i], longint'(bkwd_q[i])) + fw[i-1]);
    end
    y = fw[ORDER];
    // ascending order keeps bkwd_q[i+1] at its old value when it is read
    for (int i = 1; i < ORDER; i++) begin
      bkwd_q[i] = acc_t'(clamp32(longint'(bkwd_q[i+1]) - q15_mul(coef_q[ORDER-1-i], fw[i+1])));
    end
    bkwd_q[ORDER] = acc_t'(fw[ORDER]);
    if (y > 64'sd32767) begin
      return 16'sh7fff;
    end else if (y < -64'sd32768) begin
      return 16'sh8000;
    end
    return smp_t'(y);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    smp_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NCOEF; k++) begin
        coef_q[k] = '0;
      end
      for (int k = 1; k <= ORDER; k++) begin
        bkwd_q[k] = '0;
      end
      filtered_q.delete();
      mismatch_cnt_o <= mismatches;
      pending_o      <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen_out++;
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("result word %0d (%0d) with no sample pending",
                                    seen_out, out_mon.sample_out));
        end else begin
          want = filtered_q.pop_front();
          if (out_mon.sample_out !== want) begin
            report_mismatch($sformatf("result word %0d sample_out %0d, expected %0d",
                                      seen_out, out_mon.sample_out, want));
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.index < NCOEF) begin
        coef_q[cfg_mon.index[CI_W-1:0]] = coef_t'(cfg_mon.data);
      end
      if (in_mon.valid && in_mon.ready) begin
        filtered_q.push_back(filter_sample(in_mon.sample_in));
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= filtered_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the lattice filter with directed and random samples under several
// coefficient sets and idle patterns, including a long output stall, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  import rlf_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4 * ORDER + 8;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 194;

  localparam logic [CFG_IDX_W-1:0] REG_COEF0 = '0;

  typedef enum int {CK_ZERO, CK_MAX, CK_MIN, CK_SMALL, CK_FULL, CK_CORNER} coef_kind_e;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_req;
  int   idle_cycles;
  int   mismatch_cnt;
  int   pending;

  coef_kind_e phase_kind [RAND_PHASES] = '{CK_SMALL, CK_FULL, CK_CORNER, CK_SMALL,
                                           CK_MAX, CK_FULL, CK_SMALL, CK_MIN};

  rlf_cfg_if cfg_ch ();
  rlf_in_if  in_ch ();
  rlf_out_if out_ch ();

  recursive_lattice_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  lattice_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_mon        (cfg_ch),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // output side: random ready, or a long counted hold-off on request
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic load_coefs(coef_kind_e kind);
    coef_t c;
    for (int k = 0; k < NCOEF; k++) begin
      case (kind)
        CK_ZERO:  c = '0;
        CK_MAX:   c = 16'sh7fff;
        CK_MIN:   c = 16'sh8000;
        CK_SMALL: c = coef_t'($urandom_range(16383)) - 16'sd8192;
        CK_FULL:  c = coef_t'($urandom);
        default: begin
          case ($urandom_range(4))
            0:       c = 16'sh7fff;
            1:       c = 16'sh8000;
            2:       c = '0;
            3:       c = 16'sd1;
            default: c = -16'sd1;
          endcase
        end
      endcase
      write_reg(REG_COEF0 + CFG_IDX_W'(k), c);
    end
    // writes past the last coefficient must leave everything unchanged
    write_reg(CFG_IDX_W'(NCOEF + $urandom_range(255 - NCOEF)), coef_t'($urandom));
    write_reg('1, coef_t'($urandom));
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_sample(smp_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic run_random(int n);
    smp_t s;
    int   burst;
    burst = 0;
    s     = '0;
    for (int k = 0; k < n; k++) begin
      if (burst > 0) begin
        // a held full-scale value drives the inner sums into saturation
        burst--;
      end else begin
        case ($urandom_range(19))
          0, 1, 2: s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          3: begin
            s     = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            burst = $urandom_range(30, 5);
          end
          4, 5, 6, 7, 8: s = smp_t'($urandom_range(127)) - 16'sd64;
          default: s = smp_t'($urandom);
        endcase
      end
      send_sample(s);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    send_idle_pct   = 21;
    recv_idle_pct   = 47;
    hold_req        = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    load_coefs(CK_ZERO);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample('0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    wait_drained();

    load_coefs(CK_MAX);
    repeat (8) send_sample(16'sh7fff);
    wait_drained();

    load_coefs(CK_MIN);
    for (int k = 0; k < 6; k++) begin
      send_sample(k[0] ? 16'sh7fff : 16'sh8000);
    end
    wait_drained();

    // zero input lets the stored backward values ring out
    load_coefs(CK_CORNER);
    repeat (4) send_sample('0);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      send_idle_pct = (p < 3) ? 21 : (p < 6) ? 47 : 0;
      recv_idle_pct = (p < 3) ? 47 : (p < 6) ? 21 : 0;
      load_coefs(phase_kind[p]);
      if (p == 1 || p == 6) begin
        hold_req = 1'b1;
      end
      run_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
